>>> design/wps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wps_pkg;

    localparam int CW = 20;

    typedef logic signed [CW-1:0] t_coord;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_PLACE = 1'b1;

    localparam logic CFG_SCREEN_W = 1'b0;
    localparam logic CFG_SCREEN_H = 1'b1;

    localparam logic [12:0] SCREEN_W_RESET = 13'd1920;
    localparam logic [12:0] SCREEN_H_RESET = 13'd1080;

    typedef struct packed {
        logic signed [14:0] x;
        logic signed [14:0] y;
        logic [12:0]        w;
        logic [12:0]        h;
    } t_rect;

    typedef struct packed {
        logic   start;
        t_coord x;
        t_coord y;
    } t_score_req;

    typedef struct packed {
        logic        done;
        logic [63:0] pen;
    } t_score_rsp;

endpackage

`default_nettype wire

>>> design/wps_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module wps_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> design/wps_score.sv
`timescale 1ns / 1ps
`default_nettype none

module wps_score
    import wps_pkg::*;
#(
    parameter int MAX_WINDOWS = 16,
    parameter int AW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_score_req             i_req,
    output t_score_rsp                  o_rsp,
    input  wire logic [12:0]            i_w,
    input  wire logic [12:0]            i_h,
    input  wire logic [11:0]            i_gx,
    input  wire logic [11:0]            i_gy,
    input  wire logic                   i_self_en,
    input  wire logic [3:0]             i_self,
    input  wire logic [MAX_WINDOWS-1:0] i_valid,
    output logic      [AW-1:0]          o_rd_addr,
    input  wire logic [$bits(t_rect)-1:0] i_rd_data
);

    localparam logic [1:0] SC_IDLE = 2'd0;
    localparam logic [1:0] SC_CEN1 = 2'd1;
    localparam logic [1:0] SC_CEN2 = 2'd2;
    localparam logic [1:0] SC_RUN  = 2'd3;

    logic [1:0]    r_state;
    logic [AW-1:0] r_idx;
    logic          r_issuing;
    t_coord        r_dx, r_dy;
    logic [39:0]   r_sqx, r_sqy;
    logic          r_t1, r_t2, r_t3, r_t4;
    logic          r_l1, r_l2, r_l3, r_l4;
    logic          r_v1;
    logic [12:0]   r_hov, r_vov;
    logic [25:0]   r_a;
    logic [51:0]   r_a2;
    logic [63:0]   r_acc;
    logic          r_done;

    logic   tok0, last0, self_hit;
    t_rect  rd;
    logic [12:0] hov, vov;

    function automatic logic [12:0] f_ovl(t_coord a, t_coord ae, t_coord b, t_coord be);
        t_coord lo;
        t_coord hi;
        lo = (a > b) ? a : b;
        hi = (ae < be) ? ae : be;
        return (hi > lo) ? 13'(hi - lo) : 13'd0;
    endfunction

    assign tok0      = (r_state == SC_RUN) && r_issuing;
    assign last0     = (r_idx == AW'(MAX_WINDOWS - 1));
    assign self_hit  = i_self_en && (9'(r_idx) == {5'b0, i_self});
    assign o_rd_addr = r_idx;
    assign rd        = t_rect'(i_rd_data);

    assign hov = f_ovl(i_req.x, i_req.x + t_coord'({7'b0, i_w}),
                       t_coord'(rd.x), t_coord'(rd.x) + t_coord'({7'b0, rd.w}));
    assign vov = f_ovl(i_req.y, i_req.y + t_coord'({7'b0, i_h}),
                       t_coord'(rd.y), t_coord'(rd.y) + t_coord'({7'b0, rd.h}));

    assign o_rsp.done = r_done;
    assign o_rsp.pen  = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= SC_IDLE;
            r_issuing <= 1'b0;
            r_t1      <= 1'b0;
            r_t2      <= 1'b0;
            r_t3      <= 1'b0;
            r_t4      <= 1'b0;
            r_done    <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_done <= 1'b0;
            r_t1   <= tok0;
            r_t2   <= r_t1;
            r_t3   <= r_t2;
            r_t4   <= r_t3;
            unique case (r_state)
                SC_IDLE: begin
                    if (i_req.start) begin
                        r_state <= SC_CEN1;
                    end
                end
                SC_CEN1: begin
                    r_state <= SC_CEN2;
                end
                SC_CEN2: begin
                    r_state   <= SC_RUN;
                    r_idx     <= '0;
                    r_issuing <= 1'b1;
                end
                SC_RUN: begin
                    if (r_issuing) begin
                        if (last0) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    if (r_t4 && r_l4) begin
                        r_done  <= 1'b1;
                        r_state <= SC_IDLE;
                    end
                end
                default: r_state <= SC_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx  <= t_coord'({8'b0, i_gx}) - (i_req.x + t_coord'({8'b0, i_w[12:1]}));
        r_dy  <= t_coord'({8'b0, i_gy}) - (i_req.y + t_coord'({8'b0, i_h[12:1]}));
        r_sqx <= 40'(r_dx * r_dx);
        r_sqy <= 40'(r_dy * r_dy);
        r_l1  <= last0;
        r_l2  <= r_l1;
        r_l3  <= r_l2;
        r_l4  <= r_l3;
        r_v1  <= i_valid[r_idx] && !self_hit;
        r_hov <= r_v1 ? hov : 13'd0;
        r_vov <= r_v1 ? vov : 13'd0;
        r_a   <= {13'b0, r_hov} * {13'b0, r_vov};
        r_a2  <= {26'b0, r_a} * {26'b0, r_a};
        if (r_state == SC_CEN2) begin
            r_acc <= 64'(r_sqx) + 64'(r_sqy);
        end else if (r_state == SC_RUN && r_t4) begin
            r_acc <= r_acc + 64'(r_a2);
        end
    end

endmodule

`default_nettype wire

>>> design/wps_search.sv
`timescale 1ns / 1ps
`default_nettype none

module wps_search
    import wps_pkg::*;
#(
    parameter int COARSE_STEP = 256,
    parameter int MID_STEP    = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [12:0] i_w,
    input  wire logic [12:0] i_h,
    input  wire logic [12:0] i_sw,
    input  wire logic [12:0] i_sh,
    output t_score_req       o_req,
    input  wire t_score_rsp  i_rsp,
    output logic             o_done,
    output t_coord           o_x,
    output t_coord           o_y,
    output logic [63:0]      o_pen
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PSET = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_PEND = 3'd4;

    localparam logic [1:0] PASS_COARSE = 2'd0;
    localparam logic [1:0] PASS_MID    = 2'd1;
    localparam logic [1:0] PASS_FINE   = 2'd2;

    logic [2:0]  r_state;
    logic [1:0]  r_pass;
    logic        r_start, r_done;
    t_coord      r_cx, r_cy, r_x, r_y, r_xend, r_yend, r_step, r_bx, r_by;
    logic [63:0] r_best;
    t_coord      n_x;

    assign n_x         = r_x + r_step;
    assign o_req.start = r_start;
    assign o_req.x     = r_x;
    assign o_req.y     = r_y;
    assign o_done      = r_done;
    assign o_x         = r_cx;
    assign o_y         = r_cy;
    assign o_pen       = r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
            r_done  <= 1'b0;
            r_pass  <= PASS_COARSE;
        end else begin
            r_start <= 1'b0;
            r_done  <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cx    <= '0;
                        r_cy    <= '0;
                        r_pass  <= PASS_COARSE;
                        r_state <= S_PSET;
                    end
                end
                S_PSET: begin
                    unique case (r_pass)
                        PASS_COARSE: begin
                            r_xend <= t_coord'({7'b0, i_sw}) - t_coord'({7'b0, i_w});
                            r_yend <= t_coord'({7'b0, i_sh}) - t_coord'({7'b0, i_h});
                            r_step <= t_coord'(COARSE_STEP);
                        end
                        PASS_MID: begin
                            r_xend <= r_cx + t_coord'(COARSE_STEP);
                            r_yend <= r_cy + t_coord'(COARSE_STEP);
                            r_step <= t_coord'(MID_STEP);
                        end
                        default: begin
                            r_xend <= r_cx + t_coord'(MID_STEP);
                            r_yend <= r_cy + t_coord'(MID_STEP);
                            r_step <= t_coord'(1);
                        end
                    endcase
                    r_x     <= r_cx;
                    r_y     <= r_cy;
                    r_bx    <= r_cx;
                    r_by    <= r_cy;
                    r_best  <= '1;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_x < r_xend && r_y < r_yend) begin
                        r_start <= 1'b1;
                        r_state <= S_WAIT;
                    end else begin
                        r_state <= S_PEND;
                    end
                end
                S_WAIT: begin
                    if (i_rsp.done) begin
                        if (i_rsp.pen < r_best) begin
                            r_best <= i_rsp.pen;
                            r_bx   <= r_x;
                            r_by   <= r_y;
                        end
                        if (n_x >= r_xend) begin
                            r_x <= r_cx;
                            r_y <= r_y + r_step;
                        end else begin
                            r_x <= n_x;
                        end
                        r_state <= S_CHK;
                    end
                end
                S_PEND: begin
                    r_cx <= r_bx;
                    r_cy <= r_by;
                    if (r_pass == PASS_FINE) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_pass  <= r_pass + 2'd1;
                        r_state <= S_PSET;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/window_placement_search_unit.sv
// Table write item: written to the table when accepted, no result item.
// Place item without search: passes through T_FIN; result item registered once the output is free.
// Place item with search: each grid candidate is scored by a loop that streams every table slot
// through the one read port; ~550 candidates at 1920x1080.
// One item at a time; input stalls until the result item is in the output register.
// Reset: all slots empty, screen 1920 x 1080, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module window_placement_search_unit
    import wps_pkg::*;
#(
    parameter int MAX_WINDOWS = 16,
    parameter int COARSE_STEP = 256,
    parameter int MID_STEP    = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_req_type,
    input  wire logic [3:0]         i_slot,
    input  wire logic               i_entry_valid,
    input  wire logic signed [14:0] i_pos_x,
    input  wire logic signed [14:0] i_pos_y,
    input  wire logic [12:0]        i_size_w,
    input  wire logic [12:0]        i_size_h,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [14:0]      o_placed_x,
    output logic signed [14:0]      o_placed_y,
    output logic [3:0]              o_placed_slot,
    output logic                    o_searched,
    output logic [63:0]             o_best_penalty,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [12:0]        i_cfg_data
);

    localparam int AW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_SRCH = 2'd1;
    localparam logic [1:0] T_FIN  = 2'd2;

    logic [1:0]             r_state;
    logic [12:0]            r_sw, r_sh;
    logic [MAX_WINDOWS-1:0] r_valid;
    logic [3:0]             r_slot;
    logic                   r_in_tab;
    logic [12:0]            r_w, r_h;
    logic signed [14:0]     r_res_x, r_res_y;
    logic                   r_searched;
    logic [63:0]            r_pen;
    logic                   r_srch_start;

    logic       acc_in, in_tab, fin_go, do_search;
    logic       ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_rect      ram_wdata;
    logic [$bits(t_rect)-1:0] ram_rdata;
    t_score_req sreq;
    t_score_rsp srsp;
    logic       s_done;
    t_coord     s_x, s_y;
    logic [63:0] s_pen;

    assign o_in_stall = (r_state != T_IDLE);
    assign acc_in     = i_in_valid && !o_in_stall;
    assign in_tab     = ({5'b0, i_slot} < 9'(MAX_WINDOWS));
    assign fin_go     = (r_state == T_FIN) && (!o_out_valid || !i_out_stall);
    assign do_search  = (i_pos_x == 15'sd0) && (i_pos_y == 15'sd0)
                        && (i_size_w != r_sw) && (i_size_h != r_sh);

    always_comb begin
        if (fin_go) begin
            ram_we      = r_in_tab;
            ram_waddr   = AW'(r_slot);
            ram_wdata.x = r_res_x;
            ram_wdata.y = r_res_y;
            ram_wdata.w = r_w;
            ram_wdata.h = r_h;
        end else begin
            ram_we      = acc_in && (i_req_type == REQ_WRITE) && in_tab;
            ram_waddr   = AW'(i_slot);
            ram_wdata.x = i_pos_x;
            ram_wdata.y = i_pos_y;
            ram_wdata.w = i_size_w;
            ram_wdata.h = i_size_h;
        end
    end

    wps_ram #(
        .WIDTH ($bits(t_rect)),
        .DEPTH (MAX_WINDOWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    wps_search #(
        .COARSE_STEP (COARSE_STEP),
        .MID_STEP    (MID_STEP)
    ) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_srch_start),
        .i_w     (r_w),
        .i_h     (r_h),
        .i_sw    (r_sw),
        .i_sh    (r_sh),
        .o_req   (sreq),
        .i_rsp   (srsp),
        .o_done  (s_done),
        .o_x     (s_x),
        .o_y     (s_y),
        .o_pen   (s_pen)
    );

    wps_score #(
        .MAX_WINDOWS (MAX_WINDOWS)
    ) u_score (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (sreq),
        .o_rsp     (srsp),
        .i_w       (r_w),
        .i_h       (r_h),
        .i_gx      (r_sw[12:1]),
        .i_gy      (r_sh[12:1]),
        .i_self_en (r_in_tab),
        .i_self    (r_slot),
        .i_valid   (r_valid),
        .o_rd_addr (ram_raddr),
        .i_rd_data (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= T_IDLE;
            r_sw         <= SCREEN_W_RESET;
            r_sh         <= SCREEN_H_RESET;
            r_valid      <= '0;
            r_srch_start <= 1'b0;
            o_out_valid  <= 1'b0;
        end else begin
            r_srch_start <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SCREEN_W: r_sw <= i_cfg_data;
                    CFG_SCREEN_H: r_sh <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall && !fin_go) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                T_IDLE: begin
                    if (acc_in) begin
                        if (i_req_type == REQ_WRITE) begin
                            if (in_tab) begin
                                r_valid[AW'(i_slot)] <= i_entry_valid;
                            end
                        end else if (do_search) begin
                            r_srch_start <= 1'b1;
                            r_state      <= T_SRCH;
                        end else begin
                            r_state <= T_FIN;
                        end
                    end
                end
                T_SRCH: begin
                    if (s_done) begin
                        r_state <= T_FIN;
                    end
                end
                T_FIN: begin
                    if (fin_go) begin
                        if (r_in_tab) begin
                            r_valid[AW'(r_slot)] <= 1'b1;
                        end
                        o_out_valid <= 1'b1;
                        r_state     <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_slot     <= i_slot;
            r_in_tab   <= in_tab;
            r_w        <= i_size_w;
            r_h        <= i_size_h;
            r_res_x    <= i_pos_x;
            r_res_y    <= i_pos_y;
            r_searched <= do_search;
            r_pen      <= '1;
        end else if (r_state == T_SRCH && s_done) begin
            r_res_x <= s_x[14:0];
            r_res_y <= s_y[14:0];
            r_pen   <= s_pen;
        end
        if (fin_go) begin
            o_placed_x     <= r_res_x;
            o_placed_y     <= r_res_y;
            o_placed_slot  <= r_slot;
            o_searched     <= r_searched;
            o_best_penalty <= r_pen;
        end
    end

endmodule

`default_nettype wire
